// ----- src/ifmd_pkg.sv -----
// Shared types, codes and helpers for the interrupt flag/mask dispatcher.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package ifmd_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned CNT_W   = 6;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_sel;
    typedef logic [1:0] t_kind;

    // request types
    localparam t_req REQ_READ     = 2'd0;
    localparam t_req REQ_WRITE    = 2'd1;
    localparam t_req REQ_EVENT    = 2'd2;
    localparam t_req REQ_DISPATCH = 2'd3;

    // register selects
    localparam t_sel REG_MASK   = 2'd0;
    localparam t_sel REG_FLAG   = 2'd1;
    localparam t_sel REG_STATUS = 2'd2;

    // response kinds
    localparam t_kind KIND_READ  = 2'd0;
    localparam t_kind KIND_WDONE = 2'd1;
    localparam t_kind KIND_SRC   = 2'd2;
    localparam t_kind KIND_NONE  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // input transfer this cycle
        logic disp_start;  // dispatch with something pending: snapshot status
        logic disp_step;   // dispatch one source this cycle
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic eff_any;     // effective status non-zero
        logic pend_last;   // current dispatch step is the final one
    } t_dp_sts;

    // one-hot to binary index; bits are independent ORs
    function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [DATA_W-1:0] oh);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (oh[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- src/ifmd_ctrl.sv -----
// Controller for the interrupt dispatcher: idle / dispatch sequencing.
// Depends on ifmd_pkg for command and status structs.
`timescale 1ns / 1ps

module ifmd_ctrl
    import ifmd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req_type,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DISP = 1'b1;

    logic r_state;
    logic n_state;

    assign busy              = (r_state == ST_DISP);
    assign o_cmd.accept      = start && !busy;
    assign o_cmd.disp_start  = o_cmd.accept && (i_req_type == REQ_DISPATCH) && i_sts.eff_any;
    assign o_cmd.disp_step   = (r_state == ST_DISP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.disp_start) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_sts.pend_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/ifmd_dp.sv -----
// Datapath for the interrupt dispatcher: flag/mask registers, pending walk,
// result registers. Depends on ifmd_pkg.
`timescale 1ns / 1ps

module ifmd_dp
    import ifmd_pkg::*;
#(
    parameter int unsigned NUM_SOURCES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_req              i_req_type,
    input  t_sel              i_reg_select,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [DATA_W-1:0] i_raise_bits,
    output t_dp_sts           o_sts,
    output logic              o_valid,
    output t_kind             o_resp_kind,
    output logic [DATA_W-1:0] o_read_data,
    output logic [IDX_W-1:0]  o_source_index,
    output logic [CNT_W-1:0]  o_handled_count,
    output logic              o_last,
    output logic              o_irq_pending
);

    localparam logic [DATA_W-1:0] SRC_MASK = {DATA_W{1'b1}} >> (DATA_W - NUM_SOURCES);

    logic [DATA_W-1:0] r_flag, n_flag;
    logic [DATA_W-1:0] r_mask, n_mask;
    logic [DATA_W-1:0] r_pend, n_pend;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;

    logic              r_valid, n_valid;
    t_kind             r_kind,  n_kind;
    logic [DATA_W-1:0] r_data,  n_data;
    logic [IDX_W-1:0]  r_idx,   n_idx;
    logic [CNT_W-1:0]  r_hcnt,  n_hcnt;
    logic              r_last,  n_last;
    logic              r_irq,   n_irq;

    logic [DATA_W-1:0] eff;
    logic [DATA_W-1:0] low_bit;
    logic [DATA_W-1:0] pend_rest;

    assign eff       = r_flag & ~r_mask & SRC_MASK;
    assign low_bit   = r_pend & (~r_pend + DATA_W'(1));
    assign pend_rest = r_pend & ~low_bit;

    assign o_sts.eff_any   = |eff;
    assign o_sts.pend_last = (pend_rest == '0);

    always_comb begin
        n_flag  = r_flag;
        n_mask  = r_mask;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_kind  = KIND_READ;
        n_data  = '0;
        n_idx   = '0;
        n_hcnt  = '0;
        n_last  = 1'b1;
        n_irq   = 1'b0;

        if (i_cmd.disp_step) begin
            n_flag  = r_flag & ~low_bit;
            n_pend  = pend_rest;
            n_cnt   = r_cnt + CNT_W'(1);
            n_valid = 1'b1;
            n_kind  = KIND_SRC;
            n_idx   = onehot_to_idx(low_bit);
            n_hcnt  = r_cnt + CNT_W'(1);
            n_last  = (pend_rest == '0);
            n_irq   = (pend_rest != '0);
        end else if (i_cmd.accept) begin
            case (i_req_type)
                REQ_READ: begin
                    n_valid = 1'b1;
                    n_kind  = KIND_READ;
                    case (i_reg_select)
                        REG_MASK:   n_data = r_mask | ~SRC_MASK;
                        REG_FLAG:   n_data = r_flag;
                        REG_STATUS: n_data = eff;
                        default:    n_data = '0;
                    endcase
                    n_irq   = |eff;
                end
                REQ_WRITE: begin
                    case (i_reg_select)
                        REG_MASK: n_mask = i_write_data | ~SRC_MASK;
                        REG_FLAG: n_flag = r_flag & ~i_write_data;
                        default:  ;
                    endcase
                    n_valid = 1'b1;
                    n_kind  = KIND_WDONE;
                    n_irq   = |(n_flag & ~n_mask & SRC_MASK);
                end
                REQ_EVENT: begin
                    n_flag = r_flag | (i_raise_bits & SRC_MASK);
                end
                REQ_DISPATCH: begin
                    if (i_cmd.disp_start) begin
                        n_pend = eff;
                        n_cnt  = '0;
                    end else begin
                        n_valid = 1'b1;
                        n_kind  = KIND_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= '0;
            r_mask  <= '1;
            r_valid <= 1'b0;
        end else begin
            r_flag  <= n_flag;
            r_mask  <= n_mask;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_cnt  <= n_cnt;
        r_kind <= n_kind;
        r_data <= n_data;
        r_idx  <= n_idx;
        r_hcnt <= n_hcnt;
        r_last <= n_last;
        r_irq  <= n_irq;
    end

    assign o_valid         = r_valid;
    assign o_resp_kind     = r_kind;
    assign o_read_data     = r_data;
    assign o_source_index  = r_idx;
    assign o_handled_count = r_hcnt;
    assign o_last          = r_last;
    assign o_irq_pending   = r_irq;

endmodule

// ----- src/interrupt_flag_mask_dispatcher_core.sv -----
// Interrupt flag/mask dispatcher, top level. Register read/write: registered
// result in the cycle after the transfer, next transfer the following cycle.
// Source event: no result. Dispatch of N pending sources: busy during the
// one-source-per-cycle pending walk, one result per cycle, the first
// registered after the pending snapshot. The receiver cannot stall o_valid.
// Synchronous active-low reset masks all sources and clears all flags.
`timescale 1ns / 1ps

// Structure:
//   ifmd_ctrl - two-state sequencer (idle / dispatch), drives busy.
//   ifmd_dp   - flag and mask registers, pending snapshot walked lowest
//               bit first, registered result ports.
// Effective status = flag AND NOT mask, restricted to NUM_SOURCES bits.
// Flag writes clear bits written as one; status writes are ignored but
// still answer write done.

module interrupt_flag_mask_dispatcher_core
    import ifmd_pkg::*;
#(
    parameter int unsigned NUM_SOURCES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [1:0]        i_reg_select,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [DATA_W-1:0] i_raise_bits,
    output logic              o_valid,
    output logic [1:0]        o_resp_kind,
    output logic [DATA_W-1:0] o_read_data,
    output logic [IDX_W-1:0]  o_source_index,
    output logic [CNT_W-1:0]  o_handled_count,
    output logic              o_last,
    output logic              o_irq_pending
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller: accepts transfers, sequences the dispatch walk
    ifmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // datapath: register file, pending walk and result registers
    ifmd_dp #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req_type),
        .i_reg_select    (i_reg_select),
        .i_write_data    (i_write_data),
        .i_raise_bits    (i_raise_bits),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_resp_kind     (o_resp_kind),
        .o_read_data     (o_read_data),
        .o_source_index  (o_source_index),
        .o_handled_count (o_handled_count),
        .o_last          (o_last),
        .o_irq_pending   (o_irq_pending)
    );

endmodule

// ----- sim/tb.sv -----
// Testbench for interrupt_flag_mask_dispatcher_core: directed and random register, source
// event and dispatch traffic, checked field by field against an in-bench predictor.
// Depends on src/ifmd_pkg.sv and the RTL of the core.
`timescale 1ns / 1ps

module tb;
    import ifmd_pkg::*;

    localparam int unsigned NSRC = 32;
    // implemented sources; bits above NSRC never flag and always read masked
    localparam logic [DATA_W-1:0] SRC_MASK = {DATA_W{1'b1}} >> (DATA_W - NSRC);
    // address with no register behind it
    localparam t_sel REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_LIMIT  = 2000;

    typedef struct {
        t_kind             kind;
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  cnt;
        logic              last;
        logic              pend;
    } t_resp;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_req_type;
    logic [1:0]        i_reg_select;
    logic [DATA_W-1:0] i_write_data;
    logic [DATA_W-1:0] i_raise_bits;
    logic              o_valid;
    logic [1:0]        o_resp_kind;
    logic [DATA_W-1:0] o_read_data;
    logic [IDX_W-1:0]  o_source_index;
    logic [CNT_W-1:0]  o_handled_count;
    logic              o_last;
    logic              o_irq_pending;

    // predictor state, mirrors the block's flag and mask registers
    logic [DATA_W-1:0] irq_flags;
    logic [DATA_W-1:0] irq_mask;

    t_resp expected_resp_q[$];
    int    errors;
    int    items_sent;
    bit    burst;       // no idle cycles between transfers while set

    interrupt_flag_mask_dispatcher_core #(
        .NUM_SOURCES(NSRC)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_reg_select    (i_reg_select),
        .i_write_data    (i_write_data),
        .i_raise_bits    (i_raise_bits),
        .o_valid         (o_valid),
        .o_resp_kind     (o_resp_kind),
        .o_read_data     (o_read_data),
        .o_source_index  (o_source_index),
        .o_handled_count (o_handled_count),
        .o_last          (o_last),
        .o_irq_pending   (o_irq_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [DATA_W-1:0] effective_status();
        return irq_flags & ~irq_mask & SRC_MASK;
    endfunction

    function automatic void push_resp(t_kind kind, logic [DATA_W-1:0] data,
                                      int idx, int cnt, logic last);
        t_resp r;
        r.kind = kind;
        r.data = data;
        r.idx  = IDX_W'(idx);
        r.cnt  = CNT_W'(cnt);
        r.last = last;
        // pending flag is taken after this result's own action
        r.pend = (effective_status() != '0);
        expected_resp_q.push_back(r);
    endfunction

    // Updates the register copies for one accepted transfer and queues the
    // responses it should produce.
    function automatic void predict_response(t_req req, t_sel sel,
                                             logic [DATA_W-1:0] wdata,
                                             logic [DATA_W-1:0] raise);
        logic [DATA_W-1:0] walk;
        logic [DATA_W-1:0] rdata;
        int n;
        case (req)
            REQ_READ: begin
                case (sel)
                    REG_MASK:   rdata = irq_mask | ~SRC_MASK;
                    REG_FLAG:   rdata = irq_flags;
                    REG_STATUS: rdata = effective_status();
                    default:    rdata = '0;
                endcase
                push_resp(KIND_READ, rdata, 0, 0, 1'b1);
            end
            REQ_WRITE: begin
                // status and the unused address swallow the write
                if (sel == REG_MASK) begin
                    irq_mask = wdata | ~SRC_MASK;
                end else if (sel == REG_FLAG) begin
                    irq_flags &= ~wdata;
                end
                push_resp(KIND_WDONE, '0, 0, 0, 1'b1);
            end
            REQ_EVENT: begin
                irq_flags |= raise & SRC_MASK;
            end
            default: begin
                walk = effective_status();
                n = 0;
                if (walk == '0) begin
                    push_resp(KIND_NONE, '0, 0, 0, 1'b1);
                end else begin
                    // lowest index first, flag cleared as each source is handled
                    for (int i = 0; i < DATA_W; i++) begin
                        if (walk[i]) begin
                            walk[i] = 1'b0;
                            irq_flags[i] = 1'b0;
                            n++;
                            push_resp(KIND_SRC, '0, i, n, walk == '0);
                        end
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Response checker: every strobed result is taken at the edge ending it
    // ------------------------------------------------------------------

    function automatic void cmp_field(string name, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_resp exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_resp_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual kind %0d",
                         $time, o_resp_kind);
                errors++;
            end else begin
                exp_r = expected_resp_q.pop_front();
                cmp_field("resp_kind",     DATA_W'(exp_r.kind), DATA_W'(o_resp_kind));
                cmp_field("read_data",     exp_r.data,          o_read_data);
                cmp_field("source_index",  DATA_W'(exp_r.idx),  DATA_W'(o_source_index));
                cmp_field("handled_count", DATA_W'(exp_r.cnt),  DATA_W'(o_handled_count));
                cmp_field("last",          DATA_W'(exp_r.last), DATA_W'(o_last));
                cmp_field("irq_pending",   DATA_W'(exp_r.pend), DATA_W'(o_irq_pending));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Called at a rising edge. An idle gap lowers start first; with no gap
    // start stays high straight into the next transfer.
    task automatic send_item(t_req req, t_sel sel, logic [DATA_W-1:0] wdata,
                             logic [DATA_W-1:0] raise);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_reg_select <= sel;
        i_write_data <= wdata;
        i_raise_bits <= raise;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_response(req, sel, wdata, raise);
        items_sent++;
    endtask

    task automatic read_reg(t_sel sel);
        send_item(REQ_READ, sel, $urandom, $urandom);
    endtask

    task automatic write_reg(t_sel sel, logic [DATA_W-1:0] wdata);
        send_item(REQ_WRITE, sel, wdata, $urandom);
    endtask

    task automatic raise_sources(logic [DATA_W-1:0] raise);
        send_item(REQ_EVENT, t_sel'($urandom_range(0, 3)), $urandom, raise);
    endtask

    task automatic dispatch();
        send_item(REQ_DISPATCH, t_sel'($urandom_range(0, 3)), $urandom, $urandom);
    endtask

    // holds off the sender until all queued results are back or DRAIN_LIMIT is reached
    task automatic wait_drained();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_resp_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_pattern();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return {{(DATA_W-1){1'b0}}, 1'b1} << $urandom_range(0, DATA_W - 1);
            2:       return '1;
            3:       return '0;
            4:       return $urandom & $urandom & $urandom;
            default: return ~($urandom & $urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // everything masked and no flags after reset; dispatch finds nothing
    task automatic test_reset_values();
        read_reg(REG_MASK);
        read_reg(REG_FLAG);
        read_reg(REG_STATUS);
        read_reg(REG_UNUSED);
        dispatch();
    endtask

    // mask write, all sources raised, flag write-one-to-clear of the top half
    task automatic test_register_access();
        write_reg(REG_MASK, '0);
        read_reg(REG_MASK);
        raise_sources('1);
        read_reg(REG_FLAG);
        read_reg(REG_STATUS);
        write_reg(REG_FLAG, 32'hFFFF_0000);
        read_reg(REG_FLAG);
    endtask

    // half-full walk, then the full 32-source walk, then an empty one
    task automatic test_dispatch_walk();
        dispatch();
        raise_sources('1);
        dispatch();
        dispatch();
    endtask

    // ignored writes, masked-out pending flag, zero-valued writes and events
    task automatic test_special_cases();
        write_reg(REG_STATUS, '1);
        write_reg(REG_UNUSED, '1);
        read_reg(REG_UNUSED);
        write_reg(REG_MASK, '1);
        raise_sources(32'h0000_0001);
        dispatch();
        write_reg(REG_MASK, '0);
        write_reg(REG_FLAG, '0);
        dispatch();
        raise_sources('0);
    endtask

    // Mostly raise/unmask/dispatch sequences with random content, plus noise
    // transfers, burst stretches and the odd full drain.
    task automatic test_random_traffic();
        int first;
        int scen;
        int n;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 5) == 0);
            scen = $urandom_range(0, 9);
            case (scen)
                0, 1, 2, 3, 4, 5: begin
                    n = $urandom_range(1, 3);
                    repeat (n) raise_sources(rand_pattern());
                    if ($urandom_range(0, 1)) begin
                        write_reg(REG_MASK, rand_pattern());
                    end
                    dispatch();
                    if ($urandom_range(0, 1)) begin
                        read_reg(t_sel'($urandom_range(0, 3)));
                    end
                end
                6: begin
                    raise_sources(rand_pattern());
                    write_reg(REG_FLAG, rand_pattern());
                    read_reg(REG_FLAG);
                end
                7: begin
                    send_item(t_req'($urandom_range(0, 3)), t_sel'($urandom_range(0, 3)),
                              $urandom, $urandom);
                end
                8: begin
                    read_reg(REG_MASK);
                    read_reg(REG_FLAG);
                    read_reg(REG_STATUS);
                end
                default: begin
                    wait_drained();
                    dispatch();
                end
            endcase
        end
        burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        errors       = 0;
        items_sent   = 0;
        burst        = 1'b0;
        irq_flags    = '0;
        irq_mask     = '1;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_req_type   <= REQ_READ;
        i_reg_select <= REG_MASK;
        i_write_data <= '0;
        i_raise_bits <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_register_access();
        test_dispatch_walk();
        test_special_cases();
        test_random_traffic();

        // let the last transfer finish and any stray result show up
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (expected_resp_q.size() != 0) begin
            $display("%0t: results missing, expected %0d more actual 0",
                     $time, expected_resp_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ifmd_pkg.sv
src/ifmd_ctrl.sv
src/ifmd_dp.sv
src/interrupt_flag_mask_dispatcher_core.sv
sim/tb.sv
